// ===== sv/mbpb_pkg.sv =====
package mbpb_pkg;

   // Field widths of the pixel stream.
   localparam int unsigned COORD_W = 8;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned PIX_PER_BYTE = 8;
   localparam int unsigned PIX_IDX_W = 3;
   localparam int unsigned BYTE_COL_W = 5;

   // Configuration port geometry.
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // Register reset values.
   localparam logic [COORD_W-1:0] ORIGIN_X_RESET = 8'd0;
   localparam logic [COORD_W-1:0] ORIGIN_Y_RESET = 8'd0;
   localparam logic [COORD_W-1:0] WIDTH_RESET    = 8'd8;
   localparam logic [COORD_W-1:0] HEIGHT_RESET   = 8'd8;
   localparam logic               USE_MASK_RESET = 1'b0;

   // Register index, taken from the word address.
   typedef enum logic [2:0] {
      REG_ORIGIN_X,
      REG_ORIGIN_Y,
      REG_WIDTH,
      REG_HEIGHT,
      REG_USE_MASK
   } csr_index_type;

endpackage

// ===== sv/mbpb_if.sv =====
// Input channel: one beat carries an image byte and its mask byte.
interface mbpb_req_if;
   logic                           valid;
   logic                           ready;
   logic [mbpb_pkg::BYTE_W-1:0]    image_byte;
   logic [mbpb_pkg::BYTE_W-1:0]    mask_byte;

   modport source (output valid, output image_byte, output mask_byte, input ready);
   modport sink   (input valid, input image_byte, input mask_byte, output ready);
endinterface

// Result channel: one beat carries one pixel write.
interface mbpb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mbpb_pkg::COORD_W-1:0]   pixel_x;
   logic [mbpb_pkg::COORD_W-1:0]   pixel_y;
   logic                           pixel_on;
   logic                           last_of_byte;

   modport source (output valid, output pixel_x, output pixel_y, output pixel_on,
                   output last_of_byte, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input pixel_on,
                   input last_of_byte, output ready);
endinterface

// ===== sv/masked_bitmap_pixel_blitter_top.sv =====
// Channel   Direction  Protocol       Payload
// req_bus   in         valid/ready    image_byte, mask_byte
// rsp_bus   out        valid/ready    pixel_x, pixel_y, pixel_on, last_of_byte
// csr       in         APB write/read origin_x, origin_y, bitmap_width, bitmap_height, use_mask
//
// A byte enters the work register, then gives one pixel write per cycle while the result
// side is not stalled; the single pixel output register sets that rate. The next byte is
// taken in the cycle the last pixel of the current one moves to the output register. Reset
// is synchronous and clears the counters, the configuration registers and all valid state.
// A stalled result holds the work register, and the input once that register holds pixels.
module masked_bitmap_pixel_blitter_top (
   input  logic                              clock,
   input  logic                              reset,
   mbpb_req_if.sink                          req_bus,
   mbpb_rsp_if.source                        rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mbpb_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mbpb_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mbpb_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import mbpb_pkg::*;

   // Configuration registers.
   logic [COORD_W-1:0] origin_x_ff, origin_y_ff, width_ff, height_ff;
   logic               use_mask_ff;
   csr_index_type      csr_index;
   logic               csr_write;

   // Position counters.
   logic [COORD_W-1:0]    row_ff, row_in;
   logic [BYTE_COL_W-1:0] bcol_ff, bcol_in;

   // Work register: pixels of the current byte still to be written.
   logic [PIX_PER_BYTE-1:0] pend_ff, pend_in;
   logic [BYTE_W-1:0]       img_ff, img_in;
   logic [COORD_W-1:0]      xbase_ff, xbase_in;
   logic [COORD_W-1:0]      ypos_ff, ypos_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic               rsp_on_ff, rsp_on_in, rsp_last_ff, rsp_last_in;

   logic                    req_fire, out_free, emit;
   logic [PIX_IDX_W-1:0]    pick;
   logic [PIX_PER_BYTE-1:0] pend_left;
   logic [COORD_W:0]        eff_w, eff_h, col;
   logic [BYTE_COL_W:0]     bpr;
   logic [COORD_W-1:0]      base_col;
   logic [PIX_PER_BYTE-1:0] draw_mask;

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= ORIGIN_X_RESET;
         origin_y_ff <= ORIGIN_Y_RESET;
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         use_mask_ff <= USE_MASK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ORIGIN_X: origin_x_ff <= pwdata[COORD_W-1:0];
            REG_ORIGIN_Y: origin_y_ff <= pwdata[COORD_W-1:0];
            REG_WIDTH:    width_ff    <= pwdata[COORD_W-1:0];
            REG_HEIGHT:   height_ff   <= pwdata[COORD_W-1:0];
            REG_USE_MASK: use_mask_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      case (csr_index)
         REG_ORIGIN_X: prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, origin_x_ff};
         REG_ORIGIN_Y: prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, origin_y_ff};
         REG_WIDTH:    prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, width_ff};
         REG_HEIGHT:   prdata = {{(CSR_DATA_W-COORD_W){1'b0}}, height_ff};
         REG_USE_MASK: prdata = {{(CSR_DATA_W-1){1'b0}}, use_mask_ff};
         default:      prdata = '0;
      endcase
   end

   // Pick the leftmost pending pixel and see whether it is the byte's last one.
   always_comb begin
      pick = '0;
      for (int i = PIX_PER_BYTE - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            pick = PIX_IDX_W'(i);
         end
      end
      pend_left       = pend_ff;
      pend_left[pick] = 1'b0;
   end

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign emit          = (pend_ff != '0) && out_free;
   assign req_bus.ready = (pend_ff == '0) || (emit && (pend_left == '0));
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Geometry of the incoming byte; a zero size means 256.
   always_comb begin
      eff_w    = (width_ff == '0) ? 9'd256 : {1'b0, width_ff};
      eff_h    = (height_ff == '0) ? 9'd256 : {1'b0, height_ff};
      bpr      = 6'((eff_w + 9'd7) >> 3);
      base_col = {bcol_ff, 3'b000};
      for (int i = 0; i < PIX_PER_BYTE; i++) begin
         col          = {1'b0, base_col} + 9'(i);
         draw_mask[i] = (col < eff_w) &&
                        (!use_mask_ff || req_bus.mask_byte[PIX_PER_BYTE-1-i]);
      end
   end

   // Counter advance, byte by byte and row by row.
   always_comb begin
      row_in  = row_ff;
      bcol_in = bcol_ff;
      if (req_fire) begin
         if ({1'b0, bcol_ff} + 6'd1 >= bpr) begin
            bcol_in = '0;
            if ({1'b0, row_ff} + 9'd1 >= eff_h) begin
               row_in = '0;
            end else begin
               row_in = row_ff + 8'd1;
            end
         end else begin
            bcol_in = bcol_ff + 5'd1;
         end
      end
   end

   // Work register: load a new byte or retire the pixel just sent.
   always_comb begin
      pend_in  = pend_ff;
      img_in   = img_ff;
      xbase_in = xbase_ff;
      ypos_in  = ypos_ff;
      if (emit) begin
         pend_in = pend_left;
      end
      if (req_fire) begin
         pend_in  = draw_mask;
         img_in   = req_bus.image_byte;
         xbase_in = origin_x_ff + base_col;
         ypos_in  = origin_y_ff + row_ff;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_on_in    = rsp_on_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = xbase_ff + COORD_W'(pick);
         rsp_y_in     = ypos_ff;
         rsp_on_in    = img_ff[PIX_IDX_W'(PIX_PER_BYTE - 1) - pick];
         rsp_last_in  = (pend_left == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         bcol_ff      <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         bcol_ff      <= bcol_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      img_ff      <= img_in;
      xbase_ff    <= xbase_in;
      ypos_ff     <= ypos_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_on_ff   <= rsp_on_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pixel_x      = rsp_x_ff;
   assign rsp_bus.pixel_y      = rsp_y_ff;
   assign rsp_bus.pixel_on     = rsp_on_ff;
   assign rsp_bus.last_of_byte = rsp_last_ff;

endmodule

// ===== bench/mbpb_blit_sb_pkg.sv =====
package mbpb_blit_sb_pkg;
   import mbpb_pkg::*;

   // One pixel write as it leaves the block.
   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic               pixel_on;
      logic               last_of_byte;
   } pixel_write_type;

   // Keeps a shadow of the registers and the row/byte counters, turns each accepted
   // input beat into the pixel writes it should cause, and checks the writes that come out.
   class pixel_write_scoreboard;
      logic [COORD_W-1:0]    origin_x;
      logic [COORD_W-1:0]    origin_y;
      logic [COORD_W-1:0]    bitmap_width;
      logic [COORD_W-1:0]    bitmap_height;
      logic                  use_mask;
      logic [COORD_W-1:0]    row_idx;
      logic [BYTE_COL_W-1:0] byte_col;
      pixel_write_type       expected_writes[$];
      int unsigned           mismatches;
      int unsigned           bytes_noted;
      int unsigned           empty_bytes;
      int unsigned           writes_checked;

      function new();
         origin_x       = ORIGIN_X_RESET;
         origin_y       = ORIGIN_Y_RESET;
         bitmap_width   = WIDTH_RESET;
         bitmap_height  = HEIGHT_RESET;
         use_mask       = USE_MASK_RESET;
         row_idx        = '0;
         byte_col       = '0;
         mismatches     = 0;
         bytes_noted    = 0;
         empty_bytes    = 0;
         writes_checked = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_ORIGIN_X: origin_x = value[COORD_W-1:0];
            REG_ORIGIN_Y: origin_y = value[COORD_W-1:0];
            REG_WIDTH:    bitmap_width = value[COORD_W-1:0];
            REG_HEIGHT:   bitmap_height = value[COORD_W-1:0];
            REG_USE_MASK: use_mask = value[0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] register_value(csr_index_type idx);
         case (idx)
            REG_ORIGIN_X: return CSR_DATA_W'(origin_x);
            REG_ORIGIN_Y: return CSR_DATA_W'(origin_y);
            REG_WIDTH:    return CSR_DATA_W'(bitmap_width);
            REG_HEIGHT:   return CSR_DATA_W'(bitmap_height);
            REG_USE_MASK: return CSR_DATA_W'(use_mask);
            default:      return '0;
         endcase
      endfunction

      function int unsigned pending();
         return expected_writes.size();
      endfunction

      // Expand one accepted beat into its pixel writes, then step the counters.
      function void note_byte(logic [BYTE_W-1:0] image_byte, logic [BYTE_W-1:0] mask_byte);
         int unsigned     cols;
         int unsigned     rows;
         int unsigned     bytes_per_row;
         int unsigned     col;
         pixel_write_type wr;
         pixel_write_type writes[$];
         // A zero width or height register means the full 256.
         cols = (bitmap_width == 0) ? 256 : bitmap_width;
         rows = (bitmap_height == 0) ? 256 : bitmap_height;
         bytes_per_row = (cols + 7) / 8;
         for (int i = 0; i < PIX_PER_BYTE; i++) begin
            col = byte_col * PIX_PER_BYTE + i;
            // Padding bits past the row width, or a byte lying past the row, draw nothing.
            if (col >= cols) break;
            if (use_mask && !mask_byte[7-i]) continue;
            wr.pixel_x = COORD_W'(origin_x + col);
            wr.pixel_y = COORD_W'(origin_y + row_idx);
            wr.pixel_on = image_byte[7-i];
            wr.last_of_byte = 1'b0;
            writes.push_back(wr);
         end
         if (writes.size() == 0) begin
            empty_bytes++;
         end else begin
            writes[writes.size()-1].last_of_byte = 1'b1;
         end
         foreach (writes[k]) expected_writes.push_back(writes[k]);
         // A byte at or past the end of the row ends it; likewise for rows and the bitmap.
         if (byte_col + 1 >= bytes_per_row) begin
            byte_col = '0;
            if (row_idx + 1 >= rows) row_idx = '0;
            else row_idx = row_idx + 1'b1;
         end else begin
            byte_col = byte_col + 1'b1;
         end
         bytes_noted++;
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH: %s", what);
         mismatches++;
      endtask

      // Compare one pixel write with the oldest one still expected.
      task check_write(pixel_write_type got);
         pixel_write_type want;
         if (expected_writes.size() == 0) begin
            report_mismatch($sformatf("pixel write x=%0d y=%0d on=%0d last=%0d with none expected",
                                      got.pixel_x, got.pixel_y, got.pixel_on, got.last_of_byte));
            return;
         end
         want = expected_writes.pop_front();
         writes_checked++;
         if (got.pixel_x !== want.pixel_x)
            report_mismatch($sformatf("pixel_x %0d, expected %0d", got.pixel_x, want.pixel_x));
         if (got.pixel_y !== want.pixel_y)
            report_mismatch($sformatf("pixel_y %0d, expected %0d", got.pixel_y, want.pixel_y));
         if (got.pixel_on !== want.pixel_on)
            report_mismatch($sformatf("pixel_on %0b, expected %0b at x=%0d y=%0d",
                                      got.pixel_on, want.pixel_on, want.pixel_x, want.pixel_y));
         if (got.last_of_byte !== want.last_of_byte)
            report_mismatch($sformatf("last_of_byte %0b, expected %0b at x=%0d y=%0d",
                                      got.last_of_byte, want.last_of_byte,
                                      want.pixel_x, want.pixel_y));
      endtask
   endclass

endpackage

// ===== bench/tb_masked_bitmap_pixel_blitter_top.sv =====
module tb_masked_bitmap_pixel_blitter_top;
   import mbpb_pkg::*;
   import mbpb_blit_sb_pkg::*;

   localparam int unsigned STALL_LIMIT  = 3000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned RANDOM_BYTES = 190;
   localparam int unsigned HOLD_CYCLES  = 300;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   mbpb_req_if req_bus();
   mbpb_rsp_if rsp_bus();

   pixel_write_scoreboard pixel_sb;
   bit                    idle_enable = 1'b0;
   int unsigned           rsp_hold_cycles = 0;
   int unsigned           csr_writes = 0;
   int unsigned           stall_cycles = 0;

   masked_bitmap_pixel_blitter_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side: ready changes at the falling edge, beats are checked at the rising edge.
   // A requested hold-off keeps ready low until its count runs down.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (rsp_hold_cycles != 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_bus.ready = !(idle_enable && $urandom_range(99) < 10);
         end
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready)
            pixel_sb.check_write({rsp_bus.pixel_x, rsp_bus.pixel_y,
                                  rsp_bus.pixel_on, rsp_bus.last_of_byte});
      end
   end

   // Watchdog: ends the run when no beat or register access moves for too long.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (psel && penable)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles, %0d pixel writes outstanding",
                     STALL_LIMIT, pixel_sb.pending());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Register write followed by a read-back of the same register.
   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      pixel_sb.set_register(idx, value);
      csr_writes++;
      @(negedge clock);
      penable = 1'b0;
      pwrite = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== pixel_sb.register_value(idx))
         pixel_sb.report_mismatch($sformatf("register %s reads %0h, expected %0h",
                                            idx.name(), prdata, pixel_sb.register_value(idx)));
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   // Offer one beat, possibly after a few idle cycles; returns at the falling edge
   // after acceptance with valid still high.
   task automatic send_byte(logic [BYTE_W-1:0] image_byte, logic [BYTE_W-1:0] mask_byte);
      while (idle_enable && $urandom_range(99) < 10) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.image_byte = image_byte;
      req_bus.mask_byte = mask_byte;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pixel_sb.note_byte(image_byte, mask_byte);
      @(negedge clock);
   endtask

   // Wait until every expected write has arrived, then give a byte that draws
   // nothing time to leave the block.
   task automatic settle();
      req_bus.valid = 1'b0;
      while (pixel_sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic configure(logic [7:0] ox, logic [7:0] oy, logic [7:0] w, logic [7:0] h,
                            logic masked);
      settle();
      csr_write(REG_ORIGIN_X, CSR_DATA_W'(ox));
      csr_write(REG_ORIGIN_Y, CSR_DATA_W'(oy));
      csr_write(REG_WIDTH, CSR_DATA_W'(w));
      csr_write(REG_HEIGHT, CSR_DATA_W'(h));
      csr_write(REG_USE_MASK, CSR_DATA_W'(masked));
   endtask

   // Random image content; masks lean toward all-clear and all-set now and then.
   task automatic send_random_bytes(int unsigned count);
      logic [BYTE_W-1:0] mask_byte;
      for (int unsigned n = 0; n < count; n++) begin
         case ($urandom_range(5))
            0:       mask_byte = 8'h00;
            1:       mask_byte = 8'hFF;
            default: mask_byte = BYTE_W'($urandom);
         endcase
         send_byte(BYTE_W'($urandom), mask_byte);
      end
   endtask

   initial begin
      int unsigned sent;
      int unsigned phase;
      int unsigned bytes_per_row;
      int unsigned rows;
      int unsigned count;
      logic [7:0]  w;
      logic [7:0]  h;

      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.image_byte = '0;
      req_bus.mask_byte = '0;
      pixel_sb = new();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Reset values: 8x8 bitmap at the origin, unmasked.
      send_byte(8'hFF, 8'h00);
      send_byte(8'hA5, 8'h5A);

      // 12 wide by 3 high near the top right corner: x and y wrap, padding bits drop.
      configure(8'd250, 8'd254, 8'd12, 8'd3, 1'b0);
      send_byte(8'h80, 8'hFF);
      send_byte(8'h01, 8'h00);
      send_byte(8'hF0, 8'h0F);
      send_byte(8'h0F, 8'hF0);
      send_byte(8'h55, 8'hAA);
      send_byte(8'hAA, 8'h55);

      // One pixel, masked: a lit pixel, a byte with nothing drawn, a cleared pixel.
      configure(8'd0, 8'd0, 8'd1, 8'd1, 1'b1);
      send_byte(8'hFF, 8'h80);
      send_byte(8'hFF, 8'h7F);
      send_byte(8'h00, 8'h80);

      // Width and height of 255, masked, left mid-row.
      configure(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_byte(8'hFF, 8'h00);
      send_byte(8'h5A, 8'hFF);
      send_byte(8'hC3, 8'h81);

      // Width shrinks under the counters: the byte lies past the row and only ends it.
      configure(8'd255, 8'd255, 8'd9, 8'd255, 1'b0);
      send_byte(8'hFF, 8'hFF);

      // Height shrinks under the counters: the current row is past the last one.
      configure(8'd3, 8'd7, 8'd9, 8'd1, 1'b0);
      send_byte(8'h96, 8'h00);
      send_byte(8'hFF, 8'h00);

      // Zero width and height stand for 256.
      configure(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      send_byte(8'h3C, 8'hC3);
      send_byte(8'hE7, 8'h18);

      // Output held off for a long stretch while input keeps coming.
      configure(8'($urandom), 8'($urandom), 8'd16, 8'd4, 1'b0);
      rsp_hold_cycles = HOLD_CYCLES;
      send_random_bytes(16);
      sent = 16;

      // Random bitmaps, mostly drawn whole; some stop part way through.
      phase = 0;
      while (sent < RANDOM_BYTES) begin
         idle_enable = !(phase >= 2 && phase < 6);
         case ($urandom_range(7))
            0:       w = 8'd0;
            1:       w = 8'd1;
            2:       w = 8'd255;
            3:       w = 8'd8;
            default: w = 8'($urandom_range(1, 40));
         endcase
         case ($urandom_range(7))
            0:       h = 8'd0;
            1:       h = 8'd255;
            2:       h = 8'd1;
            default: h = 8'($urandom_range(1, 6));
         endcase
         bytes_per_row = (w == 0) ? 32 : (w + 7) / 8;
         rows = (h == 0) ? 256 : h;
         count = bytes_per_row * rows;
         if (count > 40 || $urandom_range(3) == 0) count = $urandom_range(1, 24);
         configure(8'($urandom), 8'($urandom), w, h, 1'($urandom_range(1)));
         send_random_bytes(count);
         sent += count;
         phase++;
      end

      settle();
      $display("Drove %0d bitmap bytes (%0d drawing nothing) and checked %0d pixel writes.",
               pixel_sb.bytes_noted, pixel_sb.empty_bytes, pixel_sb.writes_checked);
      $display("Used %0d register writes over %0d random bitmaps, one long output stall.",
               csr_writes, phase);
      if (pixel_sb.mismatches == 0 && pixel_sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
